>>> rtl/core/sme_pkg.sv
// Shared types and constants for the stack machine executor.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package sme_pkg;

	localparam int WORD_W          = 32;
	localparam int DATA_W          = 30;
	localparam int KIND_W          = 2;
	localparam int DIV_CNT_W       = 5;
	localparam int STACK_DEPTH_DEF = 1024;

	// primitive codes carried in the data bits of a primitive item
	localparam logic [DATA_W-1:0] PRIM_HALT = DATA_W'(0);
	localparam logic [DATA_W-1:0] PRIM_ADD  = DATA_W'(1);
	localparam logic [DATA_W-1:0] PRIM_SUB  = DATA_W'(2);
	localparam logic [DATA_W-1:0] PRIM_MUL  = DATA_W'(3);
	localparam logic [DATA_W-1:0] PRIM_DIV  = DATA_W'(4);

	typedef logic [WORD_W-1:0] word_t;

	// movement of the whole ring of stack cells, all cells at once
	typedef struct packed {
		logic mv_up;   // push: each cell takes its upper neighbour
		logic mv_dn;   // pop: each cell takes its lower neighbour
	} ring_ctl_t;

endpackage

>>> rtl/core/stack_machine_executor_unit.sv
// Stack machine executor, top level: control sequencer, ring of stack cells,
// multiplier register and iterative divider. Depends on sme_pkg, sme_cell, sme_div.
`timescale 1ns / 1ps

// Usage
//  Input channel in_valid/in_ready carries one instr_word per item; the
//  output channel out_valid/out_ready returns one item per instruction:
//  top_value, halted and div_zero.
//  The stack is a ring of STACK_DEPTH cells with the top of stack always in
//  cell 0; a push rotates the ring up one place and loads cell 0, a pop rotates
//  it down and loads cell 0 with the result. The pointer wrap is implicit.
//  Path, accept to out_valid: every result goes through the holding
//  register and then the output register; mul first registers the product,
//  div first runs the bit-serial divider, one quotient bit per cycle. Divide
//  by zero skips the divider. No new item is taken while a mul or div runs.
//  Throughput: one item per cycle, while the output is not stalled, for
//  push, add, sub, halt, unknown codes, items after halt and divide by zero.
//  A finished item sits in a holding register ahead of the output register,
//  so one new item is taken while an earlier result waits on out_ready;
//  past that, in_ready drops until the receiver takes the output.
//  Reset (arst_n low) clears every stack cell, the halt flag and all valids
//  at once; no clearing pass is needed.
//  After a halt every item is answered with the current top and halted set.
module stack_machine_executor_unit #(
	parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sme_pkg::WORD_W-1:0] instr_word,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [sme_pkg::WORD_W-1:0] top_value,
	output logic                       halted,
	output logic                       div_zero
);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

	state_t              state_q;
	logic                halt_q;

	// ring of cells
	sme_pkg::word_t      cell_val [STACK_DEPTH];
	sme_pkg::ring_ctl_t  ring_ctl;
	logic                ring_ld;
	sme_pkg::word_t      ring_ld_val;
	sme_pkg::word_t      top_w;    // entry at the pointer (b)
	sme_pkg::word_t      below_w;  // entry below the pointer (a)

	// decode
	logic                in_acc;
	logic [sme_pkg::KIND_W-1:0] kind;
	logic [sme_pkg::DATA_W-1:0] code;

	// sequencer outputs
	logic                fin;
	sme_pkg::word_t      fin_top;
	logic                fin_halt;
	logic                fin_dz;
	logic                halt_set;
	logic                go_mul;
	logic                go_div;

	// arithmetic
	logic [2*sme_pkg::WORD_W-1:0] mul_full;
	sme_pkg::word_t      prod_q;
	logic                neg_q;
	sme_pkg::word_t      mag_a;
	sme_pkg::word_t      mag_b;
	logic                dv_busy;
	logic                dv_done;
	sme_pkg::word_t      dv_quo;
	sme_pkg::word_t      div_res;

	// holding and output registers
	logic                pend_q;
	sme_pkg::word_t      pend_top_q;
	logic                pend_halt_q;
	logic                pend_dz_q;
	logic                pend_mv;
	logic                out_valid_q;
	sme_pkg::word_t      out_top_q;
	logic                out_halt_q;
	logic                out_dz_q;

	assign top_w   = cell_val[0];
	assign below_w = cell_val[1];

	assign kind   = instr_word[sme_pkg::WORD_W-1 -: sme_pkg::KIND_W];
	assign code   = instr_word[sme_pkg::DATA_W-1:0];
	assign in_acc = in_valid && in_ready;

	assign pend_mv  = pend_q && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE) && (!pend_q || pend_mv);

	assign mul_full = below_w * top_w;
	assign mag_a    = below_w[sme_pkg::WORD_W-1] ? (~below_w + 1'b1) : below_w;
	assign mag_b    = top_w[sme_pkg::WORD_W-1] ? (~top_w + 1'b1) : top_w;
	assign div_res  = neg_q ? (~dv_quo + 1'b1) : dv_quo;

	// sequencer: decides the ring move and the finished item
	always_comb begin
		ring_ctl    = '0;
		ring_ld     = 1'b0;
		ring_ld_val = top_w;
		fin         = 1'b0;
		fin_top     = top_w;
		fin_halt    = halt_q;
		fin_dz      = 1'b0;
		halt_set    = 1'b0;
		go_mul      = 1'b0;
		go_div      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					priority if (halt_q) begin
						fin = 1'b1;
					end else if (!kind[0]) begin
						// push: zero-extended data onto a new top
						ring_ctl.mv_up = 1'b1;
						ring_ld        = 1'b1;
						ring_ld_val    = {{(sme_pkg::WORD_W-sme_pkg::DATA_W){1'b0}}, code};
						fin            = 1'b1;
						fin_top        = ring_ld_val;
					end else begin
						unique case (code)
							sme_pkg::PRIM_HALT: begin
								halt_set = 1'b1;
								fin      = 1'b1;
								fin_halt = 1'b1;
							end
							sme_pkg::PRIM_ADD: begin
								ring_ctl.mv_dn = 1'b1;
								ring_ld        = 1'b1;
								ring_ld_val    = below_w + top_w;
								fin            = 1'b1;
								fin_top        = ring_ld_val;
							end
							sme_pkg::PRIM_SUB: begin
								ring_ctl.mv_dn = 1'b1;
								ring_ld        = 1'b1;
								ring_ld_val    = below_w - top_w;
								fin            = 1'b1;
								fin_top        = ring_ld_val;
							end
							sme_pkg::PRIM_MUL: begin
								go_mul = 1'b1;
							end
							sme_pkg::PRIM_DIV: begin
								if (top_w == '0) begin
									// divide by zero: pop with zero, flag it
									ring_ctl.mv_dn = 1'b1;
									ring_ld        = 1'b1;
									ring_ld_val    = '0;
									fin            = 1'b1;
									fin_top        = '0;
									fin_dz         = 1'b1;
								end else begin
									go_div = 1'b1;
								end
							end
							default: begin
								fin = 1'b1;
							end
						endcase
					end
				end
			end
			ST_MUL: begin
				ring_ctl.mv_dn = 1'b1;
				ring_ld        = 1'b1;
				ring_ld_val    = prod_q;
				fin            = 1'b1;
				fin_top        = prod_q;
			end
			ST_DIV: begin
				if (dv_done) begin
					ring_ctl.mv_dn = 1'b1;
					ring_ld        = 1'b1;
					ring_ld_val    = div_res;
					fin            = 1'b1;
					fin_top        = div_res;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			halt_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go_mul) begin
						state_q <= ST_MUL;
					end else if (go_div) begin
						state_q <= ST_DIV;
					end
				end
				ST_MUL: begin
					state_q <= ST_IDLE;
				end
				ST_DIV: begin
					if (dv_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (halt_set) begin
				halt_q <= 1'b1;
			end
			if (fin) begin
				pend_q <= 1'b1;
			end else if (pend_mv) begin
				pend_q <= 1'b0;
			end
			if (pend_mv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (go_mul) begin
			prod_q <= mul_full[sme_pkg::WORD_W-1:0];
		end
		if (go_div) begin
			neg_q <= below_w[sme_pkg::WORD_W-1] ^ top_w[sme_pkg::WORD_W-1];
		end
		if (fin) begin
			pend_top_q  <= fin_top;
			pend_halt_q <= fin_halt;
			pend_dz_q   <= fin_dz;
		end
		if (pend_mv) begin
			out_top_q  <= pend_top_q;
			out_halt_q <= pend_halt_q;
			out_dz_q   <= pend_dz_q;
		end
	end

	// stack ring: cell i sits i places below the pointer
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		sme_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ring_ctl),
			.ld     (ring_ld && (i == 0)),
			.ld_val (ring_ld_val),
			.up_in  (cell_val[(i + STACK_DEPTH - 1) % STACK_DEPTH]),
			.dn_in  (cell_val[(i + 1) % STACK_DEPTH]),
			.val    (cell_val[i])
		);
	end

	sme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_div),
		.dividend (mag_a),
		.divisor  (mag_b),
		.busy     (dv_busy),
		.done     (dv_done),
		.quotient (dv_quo)
	);

	assign out_valid = out_valid_q;
	assign top_value = out_top_q;
	assign halted    = out_halt_q;
	assign div_zero  = out_dz_q;

	// a divide by zero can only come from a running machine
	a_dz_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> !halted)
		else $error("div_zero reported on a halted item");

	// the halt flag is only cleared by reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(halt_q))
		else $error("halt flag dropped without reset");

	// while waiting on a quotient the divider is working or just finished
	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> dv_busy || dv_done)
		else $error("sequencer waits on an idle divider");

	// a finished item never lands on a held one
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !pend_q || pend_mv)
		else $error("holding register overwritten");

endmodule

>>> rtl/core/sme_cell.sv
// One stack cell: holds a single stack entry and passes it along the ring.
// Depends on sme_pkg.
`timescale 1ns / 1ps

module sme_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sme_pkg::ring_ctl_t ctl,
	input  logic               ld,
	input  sme_pkg::word_t     ld_val,
	input  sme_pkg::word_t     up_in,
	input  sme_pkg::word_t     dn_in,
	output sme_pkg::word_t     val
);

	sme_pkg::word_t val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ld) begin
			val_q <= ld_val;
		end else if (ctl.mv_up) begin
			val_q <= up_in;
		end else if (ctl.mv_dn) begin
			val_q <= dn_in;
		end
	end

	assign val = val_q;

endmodule

>>> rtl/core/sme_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on sme_pkg.
`timescale 1ns / 1ps

module sme_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  sme_pkg::word_t dividend,
	input  sme_pkg::word_t divisor,
	output logic           busy,
	output logic           done,
	output sme_pkg::word_t quotient
);

	sme_pkg::word_t                    rem_q;
	sme_pkg::word_t                    quo_q;
	sme_pkg::word_t                    dvs_q;
	logic [sme_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                              busy_q;
	logic                              done_q;
	logic [sme_pkg::WORD_W:0]          trial;

	assign trial = {rem_q, quo_q[sme_pkg::WORD_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[sme_pkg::WORD_W]) begin
				rem_q <= trial[sme_pkg::WORD_W-1:0];
				quo_q <= {quo_q[sme_pkg::WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[sme_pkg::WORD_W-2:0], quo_q[sme_pkg::WORD_W-1]};
				quo_q <= {quo_q[sme_pkg::WORD_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> sim/tb_top.sv
// Self-checking bench for stack_machine_executor_unit: instruction items in, one answer each.
// Depends on sme_pkg and the unit's RTL; keeps its own copy of the stack to predict answers.
`timescale 1ns / 1ps

module tb_top;

	localparam int WORD_W = sme_pkg::WORD_W;
	localparam int DATA_W = sme_pkg::DATA_W;
	localparam int KIND_W = sme_pkg::KIND_W;

	typedef sme_pkg::word_t word_t;

	localparam logic [DATA_W-1:0] PRIM_HALT = sme_pkg::PRIM_HALT;
	localparam logic [DATA_W-1:0] PRIM_ADD  = sme_pkg::PRIM_ADD;
	localparam logic [DATA_W-1:0] PRIM_SUB  = sme_pkg::PRIM_SUB;
	localparam logic [DATA_W-1:0] PRIM_MUL  = sme_pkg::PRIM_MUL;
	localparam logic [DATA_W-1:0] PRIM_DIV  = sme_pkg::PRIM_DIV;

	localparam int DEPTH      = sme_pkg::STACK_DEPTH_DEF;
	localparam int DRAIN_WAIT = 40;    // divider latency plus margin
	localparam int STALL_MAX  = 4000;  // cycles with no handshake before giving up

	// instruction kinds in bits 31..30
	localparam logic [KIND_W-1:0] KIND_PUSH_LO = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PRIM_LO = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH_HI = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PRIM_HI = 2'd3;

	localparam logic [DATA_W-1:0] DATA_ALL = {DATA_W{1'b1}};

	typedef struct packed {
		word_t top;
		logic  halted;
		logic  dz;
	} answer_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	word_t instr_word;
	logic  out_valid;
	logic  out_ready;
	logic signed [WORD_W-1:0] top_value;
	logic  halted;
	logic  div_zero;

	// shadow machine state
	word_t   shadow_stack [DEPTH];
	int      shadow_sp;
	bit      shadow_halt;
	answer_t answers_due [$];

	int error_count;
	bit idle_on;
	int quiet_cycles;

	stack_machine_executor_unit #(
		.STACK_DEPTH(DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.instr_word(instr_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.top_value (top_value),
		.halted    (halted),
		.div_zero  (div_zero)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic word_t push_word(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] d);
		return {kind, d};
	endfunction

	function automatic word_t prim_word(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] code);
		return {kind, code};
	endfunction

	// signed divide, truncating toward zero; most negative / -1 wraps back to itself
	function automatic word_t div_toward_zero(input word_t a, input word_t b);
		word_t ma, mb, q;
		ma = a[WORD_W-1] ? -a : a;
		mb = b[WORD_W-1] ? -b : b;
		q  = ma / mb;
		return (a[WORD_W-1] ^ b[WORD_W-1]) ? -q : q;
	endfunction

	// advance the shadow machine by one instruction and queue the answer it owes
	task automatic execute_instr(input word_t w);
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] d;
		int      below;
		word_t   a, b, r;
		answer_t ans;
		kind   = w[WORD_W-1 -: KIND_W];
		d      = w[DATA_W-1:0];
		ans.dz = 1'b0;
		if (!shadow_halt) begin
			if (kind == KIND_PUSH_LO || kind == KIND_PUSH_HI) begin
				shadow_sp = (shadow_sp == DEPTH - 1) ? 0 : shadow_sp + 1;
				shadow_stack[shadow_sp] = {{(WORD_W-DATA_W){1'b0}}, d};
			end else if (d == PRIM_HALT) begin
				shadow_halt = 1'b1;
			end else if (d == PRIM_ADD || d == PRIM_SUB || d == PRIM_MUL || d == PRIM_DIV) begin
				// a sits below the top, b is the top; pointer wraps below zero
				below = (shadow_sp == 0) ? DEPTH - 1 : shadow_sp - 1;
				a = shadow_stack[below];
				b = shadow_stack[shadow_sp];
				case (d)
					PRIM_ADD: r = a + b;
					PRIM_SUB: r = a - b;
					PRIM_MUL: r = a * b;
					default: begin
						if (b == '0) begin
							r      = '0;
							ans.dz = 1'b1;
						end else begin
							r = div_toward_zero(a, b);
						end
					end
				endcase
				shadow_stack[below] = r;
				shadow_sp = below;
			end
		end
		ans.top    = shadow_stack[shadow_sp];
		ans.halted = shadow_halt;
		answers_due.push_back(ans);
	endtask

	// one instruction item; valid stays up across back-to-back items
	task automatic send_instr(input word_t w);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		instr_word <= w;
		do @(posedge clk); while (!in_ready);
		execute_instr(w);
	endtask

	function automatic logic [DATA_W-1:0] rand_data();
		case ($urandom_range(0, 3))
			0:       return DATA_W'($urandom_range(0, 3));
			1:       return DATA_ALL - DATA_W'($urandom_range(0, 3));
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic word_t rand_push();
		return push_word($urandom_range(0, 1) ? KIND_PUSH_HI : KIND_PUSH_LO, rand_data());
	endfunction

	// arithmetic mostly, some unknown codes; never halt
	function automatic word_t rand_prim();
		logic [DATA_W-1:0] code;
		case ($urandom_range(0, 9))
			0, 1:    code = PRIM_ADD;
			2, 3:    code = PRIM_SUB;
			4, 5:    code = PRIM_MUL;
			6, 7:    code = PRIM_DIV;
			8:       code = DATA_W'($urandom_range(5, 7));
			default: begin
				code = DATA_W'($urandom);
				if (code <= PRIM_DIV) code = DATA_W'(32);
			end
		endcase
		return prim_word($urandom_range(0, 1) ? KIND_PRIM_HI : KIND_PRIM_LO, code);
	endfunction

	// ---------------- directed tests ----------------

	// arithmetic straight after reset pops past index zero into the top entry
	task automatic test_pop_from_empty();
		send_instr(prim_word(KIND_PRIM_LO, PRIM_ADD));
	endtask

	task automatic test_add_sub_wrap();
		send_instr(push_word(KIND_PUSH_LO, '0));
		send_instr(push_word(KIND_PUSH_HI, DATA_W'(1)));
		send_instr(prim_word(KIND_PRIM_HI, PRIM_SUB));        // -1
		send_instr(push_word(KIND_PUSH_LO, DATA_W'(1)));
		send_instr(prim_word(KIND_PRIM_LO, PRIM_ADD));        // wraps to 0
	endtask

	task automatic test_mul_wrap();
		send_instr(push_word(KIND_PUSH_HI, DATA_ALL));
		send_instr(push_word(KIND_PUSH_LO, DATA_ALL));
		send_instr(prim_word(KIND_PRIM_LO, PRIM_MUL));
	endtask

	task automatic test_div_cases();
		// most negative value divided by -1
		send_instr(push_word(KIND_PUSH_LO, DATA_W'(30'h2000_0000)));
		send_instr(push_word(KIND_PUSH_LO, DATA_W'(4)));
		send_instr(prim_word(KIND_PRIM_HI, PRIM_MUL));
		send_instr(push_word(KIND_PUSH_HI, '0));
		send_instr(push_word(KIND_PUSH_LO, DATA_W'(1)));
		send_instr(prim_word(KIND_PRIM_LO, PRIM_SUB));
		send_instr(prim_word(KIND_PRIM_LO, PRIM_DIV));
		// -7 / 2 truncates to -3
		send_instr(push_word(KIND_PUSH_LO, '0));
		send_instr(push_word(KIND_PUSH_LO, DATA_W'(7)));
		send_instr(prim_word(KIND_PRIM_LO, PRIM_SUB));
		send_instr(push_word(KIND_PUSH_HI, DATA_W'(2)));
		send_instr(prim_word(KIND_PRIM_HI, PRIM_DIV));
		// divide by zero
		send_instr(push_word(KIND_PUSH_LO, '0));
		send_instr(prim_word(KIND_PRIM_LO, PRIM_DIV));
	endtask

	task automatic test_unknown_codes();
		send_instr(prim_word(KIND_PRIM_LO, DATA_W'(5)));
		send_instr(prim_word(KIND_PRIM_HI, DATA_ALL));
	endtask

	// ---------------- random tests ----------------

	// shallow random walk; alternating stretches with and without idling
	task automatic test_random_mix();
		int i;
		for (i = 0; i < 300; i++) begin
			idle_on = ((i / 100) % 2) == 0;
			send_instr(($urandom_range(0, 99) < 55) ? rand_push() : rand_prim());
		end
	endtask

	// push past the full depth so old entries get overwritten
	task automatic test_deep_stack();
		int i;
		idle_on = 1'b1;
		for (i = 0; i < DEPTH + 6; i++)
			send_instr(rand_push());
	endtask

	// mostly pops back down through the filled stack
	task automatic test_unwind();
		int i;
		for (i = 0; i < 150; i++)
			send_instr(($urandom_range(0, 9) == 0) ? rand_push() : rand_prim());
	endtask

	// halt is final: everything afterwards only reports the frozen top
	task automatic test_halt();
		int i;
		send_instr(prim_word(KIND_PRIM_LO, PRIM_HALT));
		for (i = 0; i < 20; i++) begin
			case ($urandom_range(0, 3))
				0:       send_instr(rand_push());
				1:       send_instr(prim_word(KIND_PRIM_HI, PRIM_HALT));
				default: send_instr(rand_prim());
			endcase
		end
	endtask

	// ---------------- output side ----------------

	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		answer_t ans;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected item top=%0d halted=%0b div_zero=%0b",
					$time, top_value, halted, div_zero);
				error_count++;
			end else begin
				ans = answers_due.pop_front();
				if (top_value !== ans.top) begin
					$display("%0t: top_value expected %0d actual %0d",
						$time, $signed(ans.top), top_value);
					error_count++;
				end
				if (halted !== ans.halted) begin
					$display("%0t: halted expected %0b actual %0b", $time, ans.halted, halted);
					error_count++;
				end
				if (div_zero !== ans.dz) begin
					$display("%0t: div_zero expected %0b actual %0b", $time, ans.dz, div_zero);
					error_count++;
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int i;
		error_count  = 0;
		quiet_cycles = 0;
		idle_on      = 1'b1;
		shadow_sp    = 0;
		shadow_halt  = 1'b0;
		for (i = 0; i < DEPTH; i++)
			shadow_stack[i] = '0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		instr_word <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pop_from_empty();
		test_add_sub_wrap();
		test_mul_wrap();
		test_div_cases();
		test_unknown_codes();
		test_random_mix();
		test_deep_stack();
		idle_on = 1'b0;         // no idling from here to the end
		test_unwind();
		test_halt();

		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
rtl/core/sme_pkg.sv
rtl/core/sme_cell.sv
rtl/core/sme_div.sv
rtl/core/stack_machine_executor_unit.sv
sim/tb_top.sv
